FILE: src/bttc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttc_pkg: shared types, constants and micro-program for the buzzer control
// Holds field widths, command codes, the prescaler shift table, the control
// word layout and the read-only micro-program of the sequencer.
// ----------------------------------------------------------------------------
package bttc_pkg;

    // Default core clock in hertz
    localparam int unsigned CLOCK_HZ_DEF = 16000000;

    // Field widths
    localparam int OPC_W  = 3;
    localparam int DUR_W  = 16;
    localparam int FREQ_W = 16;
    localparam int DVS_W  = FREQ_W + 1;   // divisor 2*freq
    localparam int SEL_W  = 3;
    localparam int TOP_W  = 8;
    localparam int TIME_W = 32;
    localparam int PC_W   = 3;

    // Command codes
    localparam logic [OPC_W-1:0] OPC_TICK = 3'd0;
    localparam logic [OPC_W-1:0] OPC_ON   = 3'd1;
    localparam logic [OPC_W-1:0] OPC_OFF  = 3'd2;
    localparam logic [OPC_W-1:0] OPC_BEEP = 3'd3;
    localparam logic [OPC_W-1:0] OPC_TONE = 3'd4;

    // Prescaler search
    localparam int                PRESC_CNT    = 7;
    localparam logic [SEL_W-1:0]  SEL_LAST_IDX = 3'd6;
    localparam logic [SEL_W-1:0]  SEL_NO_FIT   = 3'd7;
    localparam logic [TOP_W-1:0]  TOP_NO_FIT   = 8'd255;
    localparam int                TOP_LIMIT    = 256;

    // Divisors 1,8,32,64,128,256,1024 as right shifts
    function automatic logic [3:0] presc_shift(input logic [SEL_W-1:0] idx);
        logic [3:0] sh;
        begin
            case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd5;
                3'd3:    sh = 4'd6;
                3'd4:    sh = 4'd7;
                3'd5:    sh = 4'd8;
                3'd6:    sh = 4'd10;
                default: sh = 4'd10;
            endcase
            return sh;
        end
    endfunction

    typedef logic [PC_W-1:0] pc_t;

    // Datapath micro-operations
    typedef enum logic [2:0] {
        UOP_FETCH,
        UOP_EXEC,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_SCAN_INIT,
        UOP_SCAN_STEP,
        UOP_TONE_SET,
        UOP_EMIT
    } uop_t;

    // Jump conditions; when false the step counter advances by one
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_BEAT,
        COND_SIMPLE,
        COND_DIV_MORE,
        COND_SCAN_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic beat;
        logic simple;
        logic div_more;
        logic scan_more;
        logic out_busy;
    } seq_stat_t;

    // Datapath flags
    typedef struct packed {
        logic simple;
        logic div_more;
        logic scan_more;
    } dp_flags_t;

    // Buzzer state as reported
    typedef struct packed {
        logic             is_sounding;
        logic             tone_mode;
        logic [SEL_W-1:0] prescale;
        logic [TOP_W-1:0] top;
    } dp_state_t;

    // Step addresses
    localparam pc_t PC_FETCH     = 3'd0;
    localparam pc_t PC_EXEC      = 3'd1;
    localparam pc_t PC_DIV_INIT  = 3'd2;
    localparam pc_t PC_DIV_STEP  = 3'd3;
    localparam pc_t PC_SCAN_INIT = 3'd4;
    localparam pc_t PC_SCAN_STEP = 3'd5;
    localparam pc_t PC_TONE_SET  = 3'd6;
    localparam pc_t PC_EMIT      = 3'd7;

    // Micro-program; the step after EMIT wraps round to FETCH
    function automatic ctrl_word_t ucode(input pc_t pc);
        ctrl_word_t w;
        begin
            case (pc)
                PC_FETCH:     w = '{UOP_FETCH,     COND_NO_BEAT,   PC_FETCH};
                PC_EXEC:      w = '{UOP_EXEC,      COND_SIMPLE,    PC_EMIT};
                PC_DIV_INIT:  w = '{UOP_DIV_INIT,  COND_NEVER,     PC_FETCH};
                PC_DIV_STEP:  w = '{UOP_DIV_STEP,  COND_DIV_MORE,  PC_DIV_STEP};
                PC_SCAN_INIT: w = '{UOP_SCAN_INIT, COND_NEVER,     PC_FETCH};
                PC_SCAN_STEP: w = '{UOP_SCAN_STEP, COND_SCAN_MORE, PC_SCAN_STEP};
                PC_TONE_SET:  w = '{UOP_TONE_SET,  COND_NEVER,     PC_FETCH};
                PC_EMIT:      w = '{UOP_EMIT,      COND_OUT_BUSY,  PC_EMIT};
                default:      w = '{UOP_FETCH,     COND_NO_BEAT,   PC_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/bttc_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttc_seq: micro-program sequencer
// Step counter over the read-only program; each step either jumps to its
// target when its condition holds or moves on to the next step.
// ----------------------------------------------------------------------------
module bttc_seq (
    input  wire                     clk,
    input  wire                     rst_n,
    input  bttc_pkg::seq_stat_t     stat,
    output bttc_pkg::ctrl_word_t    ctrl
);
    import bttc_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic jump;

    // Control word for the current step
    assign ctrl = ucode(pc_reg);

    // Condition select
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_NO_BEAT:   jump = !stat.beat;
            COND_SIMPLE:    jump = stat.simple;
            COND_DIV_MORE:  jump = stat.div_more;
            COND_SCAN_MORE: jump = stat.scan_more;
            COND_OUT_BUSY:  jump = stat.out_busy;
            default:        jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : pc_t'(pc_reg + 1'b1);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/bttc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttc_dp: buzzer datapath
// Command latch, millisecond time and deadline, sounding flags, a one bit per
// step restoring divider for CLOCK_HZ / (2*freq) and the prescaler scan.
// ----------------------------------------------------------------------------
module bttc_dp #(
    parameter int unsigned CLOCK_HZ = bttc_pkg::CLOCK_HZ_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  bttc_pkg::uop_t                  uop,
    input  wire                             cmd_load,
    input  wire [bttc_pkg::OPC_W-1:0]       opcode,
    input  wire [bttc_pkg::DUR_W-1:0]       duration_ms,
    input  wire [bttc_pkg::FREQ_W-1:0]      tone_freq_hz,
    output bttc_pkg::dp_flags_t             flags,
    output bttc_pkg::dp_state_t             state
);
    import bttc_pkg::*;

    localparam int QW    = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(QW);

    // Latched command
    logic [OPC_W-1:0]  cmd_op_reg;
    logic [DUR_W-1:0]  cmd_dur_reg;
    logic [FREQ_W-1:0] cmd_freq_reg;

    // Buzzer state
    logic [TIME_W-1:0] now_reg,      now_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              sounding_reg, sounding_next;
    logic              timed_reg,    timed_next;
    logic              tone_reg,     tone_next;
    logic [SEL_W-1:0]  presc_reg,    presc_next;
    logic [TOP_W-1:0]  top_reg,      top_next;

    // Divider and scan
    logic [DVS_W-1:0]  rem_reg,  rem_next;
    logic [QW-1:0]     q_reg,    q_next;
    logic [DVS_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [SEL_W-1:0]  idx_reg,  idx_next;

    logic [TIME_W-1:0] now_inc;
    logic [TIME_W-1:0] tick_diff;
    logic [TIME_W-1:0] due_time;
    logic [DVS_W:0]    rem_sh;
    logic              q_bit;
    logic [QW-1:0]     q_scaled;
    logic              fits;

    // Shared arithmetic
    assign now_inc   = now_reg + TIME_W'(1);
    assign tick_diff = now_inc - deadline_reg;
    assign due_time  = now_reg + TIME_W'(cmd_dur_reg);
    assign rem_sh    = {rem_reg, q_reg[QW-1]};
    assign q_bit     = rem_sh >= {1'b0, dvs_reg};
    assign q_scaled  = q_reg >> presc_shift(idx_reg);
    assign fits      = (q_scaled != '0) && (q_scaled <= QW'(TOP_LIMIT));

    // Flags to the sequencer
    assign flags.simple    = !((cmd_op_reg == OPC_TONE) && (cmd_freq_reg != '0));
    assign flags.div_more  = cnt_reg != '0;
    assign flags.scan_more = !fits && (idx_reg != SEL_LAST_IDX);

    assign state.is_sounding = sounding_reg;
    assign state.tone_mode   = tone_reg;
    assign state.prescale    = presc_reg;
    assign state.top         = top_reg;

    // Micro-operation decode
    always_comb
    begin
        now_next      = now_reg;
        deadline_next = deadline_reg;
        sounding_next = sounding_reg;
        timed_next    = timed_reg;
        tone_next     = tone_reg;
        presc_next    = presc_reg;
        top_next      = top_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        case (uop)
            UOP_EXEC:
            begin
                case (cmd_op_reg)
                    OPC_TICK:
                    begin
                        now_next = now_inc;
                        if (timed_reg && !tick_diff[TIME_W-1])
                        begin
                            tone_next     = 1'b0;
                            presc_next    = '0;
                            sounding_next = 1'b0;
                            timed_next    = 1'b0;
                        end
                    end
                    OPC_ON:
                    begin
                        tone_next     = 1'b0;
                        presc_next    = '0;
                        sounding_next = 1'b1;
                        timed_next    = 1'b0;
                    end
                    OPC_OFF:
                    begin
                        tone_next     = 1'b0;
                        presc_next    = '0;
                        sounding_next = 1'b0;
                        timed_next    = 1'b0;
                    end
                    OPC_BEEP:
                    begin
                        tone_next     = 1'b0;
                        presc_next    = '0;
                        sounding_next = 1'b1;
                        timed_next    = 1'b1;
                        deadline_next = due_time;
                    end
                    OPC_TONE:
                    begin
                        // zero frequency acts as off; others go to the divider
                        if (cmd_freq_reg == '0)
                        begin
                            tone_next     = 1'b0;
                            presc_next    = '0;
                            sounding_next = 1'b0;
                            timed_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        // unused codes leave the state alone
                    end
                endcase
            end
            UOP_DIV_INIT:
            begin
                rem_next = '0;
                q_next   = QW'(CLOCK_HZ);
                dvs_next = {cmd_freq_reg, 1'b0};
                cnt_next = CNT_W'(QW - 1);
            end
            UOP_DIV_STEP:
            begin
                rem_next = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
                q_next   = {q_reg[QW-2:0], q_bit};
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            UOP_SCAN_INIT:
            begin
                idx_next = '0;
            end
            UOP_SCAN_STEP:
            begin
                // first prescaler whose quotient lies in 1..256 wins
                if (fits)
                begin
                    presc_next = idx_reg + 1'b1;
                    top_next   = TOP_W'(q_scaled - QW'(1));
                end
                else if (idx_reg == SEL_LAST_IDX)
                begin
                    presc_next = SEL_NO_FIT;
                    top_next   = TOP_NO_FIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            UOP_TONE_SET:
            begin
                tone_next     = 1'b1;
                sounding_next = 1'b1;
                timed_next    = 1'b1;
                deadline_next = due_time;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            deadline_reg <= '0;
            sounding_reg <= 1'b0;
            timed_reg    <= 1'b0;
            tone_reg     <= 1'b0;
            presc_reg    <= '0;
            top_reg      <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            now_reg      <= now_next;
            deadline_reg <= deadline_next;
            sounding_reg <= sounding_next;
            timed_reg    <= timed_next;
            tone_reg     <= tone_next;
            presc_reg    <= presc_next;
            top_reg      <= top_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload: command latch and divider words
    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_op_reg   <= opcode;
            cmd_dur_reg  <= duration_ms;
            cmd_freq_reg <= tone_freq_hz;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    // A tone is always timed, sounding and has a live prescaler
    a_tone_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        tone_reg |-> (sounding_reg && timed_reg && (presc_reg != '0)))
        else $error("tone mode without sounding, timing or prescaler");

    // A timeout only runs while something sounds
    a_timed_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        timed_reg |-> sounding_reg)
        else $error("timeout armed while silent");

    // Scan index stays within the prescaler list
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= SEL_LAST_IDX)
        else $error("prescaler scan index out of range");

endmodule
`default_nettype wire

FILE: src/buzzer_tone_and_timeout_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_tone_and_timeout_control: buzzer command processor
// Micro-coded control of a buzzer: millisecond ticks with timeout, steady
// on/off, timed beep and timed square-wave tone with prescaler selection.
// ----------------------------------------------------------------------------
// One command is taken at a time and each gives one result beat. Tick, on,
// off, beep, unused codes and a zero-frequency tone pass through execute
// and emit after the accepted beat. A tone passes through execute, divider
// init, the divider steps, scan init, the scan steps, tone set and emit: the
// restoring divider forms CLOCK_HZ / (2*freq) one quotient bit per cycle,
// followed by a scan of one prescaler per cycle. A new command is taken
// while the previous result still waits in the output register.
// drive_active_high resets to 1 and is written on any cycle with cfg_wen high.
// ----------------------------------------------------------------------------
module buzzer_tone_and_timeout_control #(
    parameter int unsigned CLOCK_HZ = bttc_pkg::CLOCK_HZ_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration
    input  wire         cfg_wen,
    input  wire         cfg_wdata,      // drive_active_high
    // command stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,        // [15:0] duration_ms, [31:16] tone_freq_hz
    input  wire  [2:0]  s_tuser,        // [2:0] opcode
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata         // [0] pin_level, [1] tone_enabled,
                                        // [4:2] clock_select, [12:5] top_value,
                                        // [13] sounding, [15:14] zero
);
    import bttc_pkg::*;

    ctrl_word_t ctrl;
    seq_stat_t  stat;
    dp_flags_t  flags;
    dp_state_t  st;

    logic        act_high_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        in_acc;
    logic        out_busy;
    logic        emit;
    logic [15:0] result;

    // Handshake
    assign s_tready = (ctrl.uop == UOP_FETCH);
    assign in_acc   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign emit     = (ctrl.uop == UOP_EMIT) && !out_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.beat      = s_tvalid;
    assign stat.simple    = flags.simple;
    assign stat.div_more  = flags.div_more;
    assign stat.scan_more = flags.scan_more;
    assign stat.out_busy  = out_busy;

    bttc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    bttc_dp #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .uop          (ctrl.uop),
        .cmd_load     (in_acc),
        .opcode       (s_tuser),
        .duration_ms  (s_tdata[15:0]),
        .tone_freq_hz (s_tdata[31:16]),
        .flags        (flags),
        .state        (st)
    );

    // Result fields; tone hides the plain level and shows select and top
    always_comb
    begin
        result        = '0;
        result[0]     = (st.is_sounding && !st.tone_mode) ? act_high_reg : !act_high_reg;
        result[1]     = st.tone_mode;
        result[4:2]   = st.tone_mode ? st.prescale : '0;
        result[12:5]  = st.tone_mode ? st.top : '0;
        result[13]    = st.is_sounding;
    end

    // Polarity register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_high_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                act_high_reg <= cfg_wdata;
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= result;
        end
    end

    // One command at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("second command taken while one is in progress");

    // No tone means stopped timer and zero top
    a_no_tone_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[12:2] == '0))
        else $error("select or top reported without tone");

    // A tone always counts as sounding and shows a nonzero clock select
    a_tone_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[13] && (m_tdata[4:2] != '0)))
        else $error("tone reported without sounding or prescaler");

endmodule
`default_nettype wire
